/* rtl/core/rn_pkg.sv */
// ----------------------------------------------------------------------------
// rn_pkg: shared types for the rational normalizer
// status codes of a result item and the status bundle of the serial divider
// ----------------------------------------------------------------------------
`default_nettype none

package rn_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } rn_status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rn_div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rational_normalizer_top.sv */
// ----------------------------------------------------------------------------
// an item passes through a binary gcd phase and then two serial dividers that
// run side by side, then waits in the done state until the output register is free.
// error items (zero denominator, or negative denominator with a most negative
// part) skip the gcd and divide phases and go straight to the done state.
// throughput: one item at a time; a new item is taken once the last one has
// moved to the output register. reset clears the control state and output.
// ----------------------------------------------------------------------------
// rational_normalizer_top: fraction reduction by gcd
// sign moves to the numerator, both parts are divided by their binary gcd
// ----------------------------------------------------------------------------
`default_nettype none

module rational_normalizer_top import rn_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [WORD_BITS-1:0] num_in_i,
  input  wire logic [WORD_BITS-1:0] den_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_BITS-1:0]      num_out_o,
  output logic [WORD_BITS-2:0]      den_out_o,
  output logic [1:0]                status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned KW = $clog2(WORD_BITS);
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_num_q, out_num_d;
  logic [W-2:0] out_den_q, out_den_d;
  rn_status_e   out_st_q, out_st_d;

  logic [W-1:0] res_num_q, res_num_d;
  logic [W-2:0] res_den_q, res_den_d;
  rn_status_e   res_st_q, res_st_d;

  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [W-1:0]  mag_q, mag_d;
  logic [W-1:0]  den_q, den_d;
  logic          neg_q, neg_d;

  logic         in_acc;
  logic [W-1:0] n_pos, d_pos, n_mag;
  logic [W-1:0] a_sub_b, b_sub_a;
  logic         gcd_fin;
  logic [W-1:0] gcd_val;
  logic         out_free;

  rn_div_stat_t div_num_stat, div_den_stat;
  logic [W-1:0] quot_num, quot_den;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // sign normalization of the incoming fraction
  assign d_pos = den_in_i[W-1] ? (W'(0) - den_in_i) : den_in_i;
  assign n_pos = den_in_i[W-1] ? (W'(0) - num_in_i) : num_in_i;
  assign n_mag = n_pos[W-1] ? (W'(0) - n_pos) : n_pos;

  assign a_sub_b = a_q - b_q;
  assign b_sub_a = b_q - a_q;
  assign gcd_fin = (state_q == S_GCD) && ((a_q == '0) || (b_q == '0));
  // one operand is zero here, so the or is the gcd without the common power of two that k counts
  assign gcd_val = (a_q | b_q) << k_q;

  assign out_free = !out_valid_q || !out_stall_i;

  rn_div #(.W(W)) u_div_num (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (gcd_fin),
    .dividend_i (mag_q),
    .divisor_i  (gcd_val),
    .stat_o     (div_num_stat),
    .quot_o     (quot_num)
  );

  rn_div #(.W(W)) u_div_den (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (gcd_fin),
    .dividend_i (den_q),
    .divisor_i  (gcd_val),
    .stat_o     (div_den_stat),
    .quot_o     (quot_den)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_st_d    = out_st_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    res_st_d    = res_st_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    mag_d       = mag_q;
    den_d       = den_q;
    neg_d       = neg_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_num_d = '0;
          res_den_d = '0;
          if (den_in_i == '0) begin
            res_st_d = ST_ZERO_DEN;
            state_d  = S_DONE;
          end else if (den_in_i[W-1] && (den_in_i == SIGN || num_in_i == SIGN)) begin
            res_st_d = ST_OVERFLOW;
            state_d  = S_DONE;
          end else begin
            res_st_d = ST_OK;
            neg_d    = n_pos[W-1];
            mag_d    = n_mag;
            den_d    = d_pos;
            a_d      = n_mag;
            b_d      = d_pos;
            k_d      = '0;
            state_d  = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (gcd_fin) begin
          state_d = S_DIV;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = a_sub_b >> 1;
        end else begin
          b_d = b_sub_a >> 1;
        end
      end
      S_DIV: begin
        if (div_num_stat.done) begin
          res_num_d = neg_q ? (W'(0) - quot_num) : quot_num;
          res_den_d = quot_den[W-2:0];
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_num_d   = res_num_q;
          out_den_d   = res_den_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_den_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_num_q   <= out_num_d;
      out_den_q   <= out_den_d;
      out_st_q    <= out_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_st_q  <= res_st_d;
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    mag_q     <= mag_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
  end

  assign out_valid_o = out_valid_q;
  assign num_out_o   = out_num_q;
  assign den_out_o   = out_den_q;
  assign status_o    = out_st_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> (a_q != '0) || (b_q != '0))
    else $error("gcd operands both zero");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_num_stat.done |-> state_q == S_DIV && div_den_stat.done && !div_den_stat.busy)
    else $error("divider finished outside divide phase");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> den_out_o != '0)
    else $error("ok item with zero denominator");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> num_out_o == '0 && den_out_o == '0)
    else $error("error item carries nonzero payload");

endmodule

`default_nettype wire

/* rtl/core/rn_div.sv */
// ----------------------------------------------------------------------------
// rn_div: bit-serial restoring divider
// one quotient bit per cycle, dividend shifts out of the quotient register
// ----------------------------------------------------------------------------
`default_nettype none

module rn_div import rn_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output rn_div_stat_t      stat_o,
  output logic [W-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // next partial remainder takes the dividend bit that shifts out
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CW'(W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      rem_d  = ge ? diff[W-1:0] : trial[W-1:0];
      quo_d  = {quo_q[W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

`default_nettype wire

/* tb/tb_rational_normalizer_top.sv */
// ----------------------------------------------------------------------------
// tb_rational_normalizer_top: self-checking bench for the fraction reducer
// drives fractions through the valid/stall input port, predicts each reduced
// fraction and its status, and checks results in order as they leave the block
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rational_normalizer_top;
  import rn_pkg::*;

  localparam int unsigned WB        = 32;
  localparam int          HALF_CLK  = 6;
  localparam int          LATENCY   = 3 * WB + 4;
  localparam int          MAX_CYCLE = 1_000_000;

  localparam logic [WB-1:0] MOST_NEG = {1'b1, {(WB-1){1'b0}}};
  localparam logic [WB-1:0] MOST_POS = ~MOST_NEG;

  typedef struct {
    logic [WB-1:0] num;
    logic [WB-2:0] den;
    rn_status_e    st;
  } fraction_t;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  logic [WB-1:0] num_in    = '0;
  logic [WB-1:0] den_in    = '0;
  logic          out_stall = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic [WB-1:0] num_out_o;
  logic [WB-2:0] den_out_o;
  logic [1:0]    status_o;

  fraction_t reduced_q[$];
  fraction_t want;
  int        mismatches = 0;
  int        cycle_cnt  = 0;
  bit        idle_on    = 1'b1;

  rational_normalizer_top #(
    .WORD_BITS(WB)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .num_in_i   (num_in),
    .den_in_i   (den_in),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .num_out_o  (num_out_o),
    .den_out_o  (den_out_o),
    .status_o   (status_o)
  );

  always #HALF_CLK clk_i = ~clk_i;

  // normal form: positive denominator, both parts divided by the gcd
  function automatic fraction_t reduce_fraction(logic [WB-1:0] n, logic [WB-1:0] d);
    fraction_t     r;
    logic          neg;
    logic [WB-1:0] mag, a, b, t;
    r.num = '0;
    r.den = '0;
    r.st  = ST_OK;
    if (d == '0) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    if (d[WB-1]) begin
      if (d == MOST_NEG || n == MOST_NEG) begin
        r.st = ST_OVERFLOW;
        return r;
      end
      d = -d;
      n = -n;
    end
    neg = n[WB-1];
    // most negative numerator keeps its magnitude as an unsigned 2^(WB-1)
    mag = neg ? -n : n;
    a = mag;
    b = d;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    mag = mag / a;
    d   = d / a;
    r.num = neg ? -mag : mag;
    r.den = d[WB-2:0];
    return r;
  endfunction

  function automatic logic [WB-1:0] pick_operand();
    logic [WB-1:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: w = $urandom_range(0, 20);
      2: w = 1 << $urandom_range(0, WB - 1);
      3: w = $urandom_range(1, 1000) * $urandom_range(1, 1000);
      4: begin
        case ($urandom_range(0, 3))
          0: w = MOST_NEG;
          1: w = MOST_POS;
          2: w = MOST_NEG + 1;
          default: w = 1;
        endcase
      end
      default: w = $urandom_range(0, 255) << $urandom_range(0, 20);
    endcase
    if ($urandom_range(0, 1)) w = -w;
    return w;
  endfunction

  task automatic push_fraction(logic [WB-1:0] n, logic [WB-1:0] d);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    num_in   = n;
    den_in   = d;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    reduced_q.push_back(reduce_fraction(n, d));
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    push_fraction(0, 1);
    push_fraction(0, -5);
    push_fraction(5, 0);
    push_fraction(0, 0);
    push_fraction(MOST_NEG, 0);
    push_fraction(MOST_NEG, -1);
    push_fraction(3, MOST_NEG);
    push_fraction(MOST_NEG, MOST_NEG);
    push_fraction(0, MOST_NEG);
    push_fraction(MOST_NEG, 1);
    push_fraction(MOST_NEG, 6);
    push_fraction(MOST_NEG, MOST_POS);
    push_fraction(MOST_POS, MOST_POS);
    push_fraction(MOST_POS, 1);
    push_fraction(MOST_NEG + 1, -1);
    push_fraction(MOST_POS, MOST_NEG + 1);
    push_fraction(6, -4);
    push_fraction(-6, -4);
    push_fraction(12, 18);
    push_fraction(1, -1);
    push_fraction(-1, MOST_POS);
    push_fraction(1 << 30, 1 << 20);
    push_fraction(-7, 7);
    push_fraction(32'hffff_fffe, 32'h0000_0002);
  endtask

  task automatic test_random_fractions(int count);
    logic [WB-1:0] n, d, g;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // shared factor so the reduction has real work to do
          g = $urandom_range(1, 1 << 15);
          n = g * $urandom_range(0, (1 << 16) - 1);
          d = g * $urandom_range(1, 1 << 15);
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        4, 5, 6: begin
          n = pick_operand();
          d = pick_operand();
        end
        7, 8: begin
          n = $urandom();
          d = $urandom();
        end
        default: begin
          n = pick_operand();
          d = $urandom_range(0, 1) ? 1 : -1;
        end
      endcase
      push_fraction(n, d);
    end
  endtask

  task automatic test_error_mix(int count);
    logic [WB-1:0] n, d;
    for (int i = 0; i < count; i++) begin
      n = $urandom_range(0, 2) == 0 ? MOST_NEG : pick_operand();
      case ($urandom_range(0, 3))
        0: d = '0;
        1: d = MOST_NEG;
        2: d = $urandom() | MOST_NEG;
        default: d = pick_operand();
      endcase
      push_fraction(n, d);
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    test_random_fractions(count);
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random_fractions(90);
    hold_until_drained();
    test_error_mix(20);
    hold_until_drained();
    test_random_fractions(70);
  endtask

  // output back-pressure, one draw per result
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (reduced_q.size() == 0) begin
        $display("%0t unexpected item: num %h den %h status %0d",
                 $time, num_out_o, den_out_o, status_o);
        mismatches++;
      end else begin
        want = reduced_q.pop_front();
        if (num_out_o !== want.num) begin
          $display("%0t num_out: expected %h actual %h", $time, want.num, num_out_o);
          mismatches++;
        end
        if (den_out_o !== want.den) begin
          $display("%0t den_out: expected %h actual %h", $time, want.den, den_out_o);
          mismatches++;
        end
        if (status_o !== want.st) begin
          $display("%0t status: expected %0d actual %0d", $time, want.st, status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("%0t timeout with %0d items outstanding", $time, reduced_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_fractions(880);
    test_error_mix(200);
    test_back_to_back(250);
    test_drain_pause();

    @(negedge clk_i);
    in_valid = 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
